[rtl/core/ifd_pkg.sv]
// ifd_pkg: shared types and constants for the IMU fall detector.
// Transaction structs, register indexes and reset levels.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ifd_pkg;

  localparam int unsigned AxisW   = 16;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned GyroW   = 17;
  localparam int unsigned SqW     = 32;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgAddrW-1:0] RegFreeFall = 2'd0;
  localparam logic [CfgAddrW-1:0] RegImpact   = 2'd1;
  localparam logic [CfgAddrW-1:0] RegGyro     = 2'd2;
  localparam logic [CfgAddrW-1:0] RegCooldown = 2'd3;

  localparam logic OpSample = 1'b0;
  localparam logic OpTick   = 1'b1;

  // reset levels, squared where the compare works on squared magnitude
  localparam logic [SqW-1:0]    FreeFallSqRst = 32'd49000000;
  localparam logic [SqW-1:0]    ImpactSqRst   = 32'd324000000;
  localparam logic [GyroW-1:0]  GyroRst       = 17'd2000;
  localparam logic [LevelW-1:0] CooldownRst   = 16'd3000;
  localparam logic [LevelW-1:0] ElapsedMax    = 16'hFFFF;

  typedef struct packed {
    logic                    op;
    logic signed [AxisW-1:0] accel_x;
    logic signed [AxisW-1:0] accel_y;
    logic signed [AxisW-1:0] accel_z;
    logic signed [AxisW-1:0] gyro_x;
    logic signed [AxisW-1:0] gyro_y;
    logic signed [AxisW-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic fall_detected;
    logic free_fall_armed;
  } out_item_t;

  function automatic logic [AxisW-1:0] abs16(input logic signed [AxisW-1:0] v);
    logic [AxisW-1:0] r;
    r = v[AxisW-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/imu_fall_detector.sv]
// imu_fall_detector: threshold fall detection on raw six-axis samples.
// Uses ifd_pkg for transaction structs, register indexes and reset levels.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data): each transaction is either a
//   one-millisecond tick (op = 1) or a sensor sample (op = 0).
//   Result channel (out_valid/out_stall/out_data): exactly one result per
//   input transaction, in order: fall_detected and the free-fall flag.
//   Config port (cfg_we/cfg_addr/cfg_wdata): free-fall level, impact level,
//   gyro spike level, cooldown in ms. Write only while the block is idle.
//   Throughput: one transaction per cycle while in_stall is low; three
//   16x16 squares in the first stage, one 32-bit add and compares plus
//   the state update in the second, then the output register.
//   Reset: pipeline emptied, flag cleared, elapsed counter at 0 (cooldown
//   active), levels back to defaults.
//   When out_stall is high the result holds; the two internal stages keep
//   filling, and in_stall rises only once both stages and the output hold
//   transactions.
`timescale 1ns / 1ps
`default_nettype none

module imu_fall_detector (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire ifd_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output ifd_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [ifd_pkg::CfgAddrW-1:0]   cfg_addr,
  input  wire logic [ifd_pkg::CfgDataW-1:0]   cfg_wdata
);
  import ifd_pkg::*;

  // config
  logic [SqW-1:0]    ff_sq_r, im_sq_r;
  logic [GyroW-1:0]  gyro_lvl_r;
  logic [LevelW-1:0] cooldown_r;
  logic [SqW-1:0]    cfg_sq;

  // stage 1: input register
  logic     s1_valid_r;
  in_item_t s1_r;
  // stage 2: products
  logic             s2_valid_r;
  logic             s2_op_r;
  logic [SqW-1:0]   s2_horiz_r;
  logic [SqW-2:0]   s2_vert_r;
  logic             s2_az_neg_r;
  logic [GyroW-1:0] s2_gsum_r;
  // state
  logic              armed_r, armed_nxt;
  logic [LevelW-1:0] elapsed_r, elapsed_nxt;
  logic              out_valid_r;
  out_item_t         out_r, out_nxt;

  logic out_take, s2_ready, s1_ready, s1_load, s2_load, s2_adv;
  logic [AxisW-1:0] mx, my, mz, gx, gy, gz;
  logic [SqW-1:0]   horiz;
  logic [SqW-2:0]   vert;
  logic [GyroW-1:0] gsum;
  logic [SqW-1:0]   mag2;
  logic             spike, tilt, arm_now, fall;

  assign out_take = !out_valid_r || !out_stall;
  assign s2_ready = !s2_valid_r || out_take;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;
  assign s1_load  = in_valid && s1_ready;
  assign s2_load  = s1_valid_r && s2_ready;
  assign s2_adv   = s2_valid_r && out_take;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // config writes
  assign cfg_sq = {16'd0, cfg_wdata[LevelW-1:0]} * {16'd0, cfg_wdata[LevelW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_sq_r    <= FreeFallSqRst;
      im_sq_r    <= ImpactSqRst;
      gyro_lvl_r <= GyroRst;
      cooldown_r <= CooldownRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegFreeFall: ff_sq_r    <= cfg_sq;
        RegImpact:   im_sq_r    <= cfg_sq;
        RegGyro:     gyro_lvl_r <= cfg_wdata;
        RegCooldown: cooldown_r <= cfg_wdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1 math
  always_comb begin
    mx    = abs16(s1_r.accel_x);
    my    = abs16(s1_r.accel_y);
    mz    = abs16(s1_r.accel_z);
    gx    = abs16(s1_r.gyro_x);
    gy    = abs16(s1_r.gyro_y);
    gz    = abs16(s1_r.gyro_z);
    horiz = ({16'd0, mx} * {16'd0, mx}) + ({16'd0, my} * {16'd0, my});
    vert  = (SqW-1)'({16'd0, mz} * {16'd0, mz});
    gsum  = {1'b0, gx} + {1'b0, gy} + {1'b0, gz};
  end

  // stage 2 decision
  always_comb begin
    mag2        = s2_horiz_r + {1'b0, s2_vert_r};
    spike       = s2_gsum_r > gyro_lvl_r;
    tilt        = s2_az_neg_r || (s2_horiz_r > {1'b0, s2_vert_r});
    arm_now     = armed_r || (mag2 < ff_sq_r);
    fall        = 1'b0;
    armed_nxt   = armed_r;
    elapsed_nxt = elapsed_r;
    if (s2_op_r == OpTick) begin
      if (elapsed_r != ElapsedMax) elapsed_nxt = elapsed_r + 1'b1;
    end else if (elapsed_r >= cooldown_r) begin
      armed_nxt = arm_now;
      if (arm_now && (mag2 > im_sq_r) && (spike || tilt)) begin
        fall        = 1'b1;
        armed_nxt   = 1'b0;
        elapsed_nxt = '0;
      end
    end
    out_nxt.fall_detected   = fall;
    out_nxt.free_fall_armed = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      armed_r     <= 1'b0;
      elapsed_r   <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
        armed_r     <= armed_nxt;
        elapsed_r   <= elapsed_nxt;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_load) s1_r <= in_data;
    if (s2_load) begin
      s2_op_r     <= s1_r.op;
      s2_horiz_r  <= horiz;
      s2_vert_r   <= vert;
      s2_az_neg_r <= s1_r.accel_z[AxisW-1];
      s2_gsum_r   <= gsum;
    end
    if (s2_adv) out_r <= out_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/ifd_checker.sv]
// ifd_checker: port-level assertions for imu_fall_detector.
// Uses ifd_pkg transaction structs; bound to the top level below.
`timescale 1ns / 1ps
`default_nettype none

module ifd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ifd_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fall_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fall_detected |-> !out_data.free_fall_armed)
    else $error("fall reported with flag still armed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind imu_fall_detector ifd_checker u_ifd_checker (.*);

`default_nettype wire
